// ===== design/upd_pkg.sv =====
// Shared types and character constants for the URL percent decoder.
package upd_pkg;

	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam int MAX_OUT = 3;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_PCT  = 2'd1,
		PH_HEX  = 2'd2
	} phase_t;

	// All decoded bytes of one input item, in slot order.
	typedef struct packed {
		logic [1:0]                cnt;
		logic                      bare;
		logic                      last;
		logic [MAX_OUT-1:0][7:0]   slot;
	} bundle_t;

	typedef struct packed {
		phase_t phase;
		logic   busy;
	} front_stat_t;

endpackage

// ===== design/url_percent_decoder.sv =====
// Top level of the URL percent decoder.
// Decodes a URL-encoded byte stream: '+' gives a space, '%' with two hex digits gives that
// byte (a decoded carriage return is dropped), a broken escape is passed on literally, and
// in_last flushes any pending escape and marks the final result with out_last (a bare end
// marker with out_has_byte low if the string closes with nothing to give). An item is
// taken every cycle while the queue has room; each result leaves through the output
// register at one per cycle unless the output is stalled, so an item that yields several
// results holds the output until all of them have left, and items that yield one result or
// none sustain one item per cycle. Each bundle is written into the queue at its transfer
// and moves into the output register once it is at the head and the register is free.
// QUEUE_DEPTH bundles (at least 2) absorb items that expand to several bytes.
module url_percent_decoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_has_byte,
	output logic       out_last
);

	logic                 q_full;
	logic                 q_empty;
	logic                 push;
	logic                 pop;
	upd_pkg::bundle_t     push_data;
	upd_pkg::bundle_t     head;
	upd_pkg::front_stat_t front_stat;

	upd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data),
		.stat      (front_stat)
	);

	upd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.full      (q_full),
		.empty     (q_empty),
		.head      (head)
	);

	upd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.head         (head),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.out_has_byte (out_has_byte),
		.out_last     (out_last)
	);

`ifndef SYNTHESIS
	a_bare_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_has_byte |-> out_last)
		else $error("bare end marker without out_last");

	a_last_clears_escape: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_last |=> !front_stat.busy)
		else $error("escape still pending after end of string");

	a_out_from_queue: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!q_empty))
		else $error("result shown with nothing queued");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("bundle pushed into a full queue");
`endif

endmodule

// ===== design/upd_front.sv =====
// Front end: accepts raw bytes, runs the escape state and packs results into a bundle.
module upd_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            in_byte,
	input  logic                  in_last,
	input  logic                  q_full,
	output logic                  push,
	output upd_pkg::bundle_t      push_data,
	output upd_pkg::front_stat_t  stat
);

	upd_pkg::phase_t  phase_q;
	upd_pkg::phase_t  phase_d;
	logic [7:0]       held_q;
	logic [7:0]       held_d;
	upd_pkg::bundle_t bd;
	logic             accept;
	logic             fresh_pct;
	logic [7:0]       fresh_val;
	logic [7:0]       code;

	function automatic logic is_hex(input logic [7:0] b);
		is_hex = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
			(b >= 8'h61 && b <= 8'h66);
	endfunction

	// Letters of either case have the digit value in the low nibble plus nine.
	function automatic logic [3:0] hex_val(input logic [7:0] b);
		hex_val = (b <= 8'h39) ? b[3:0] : (b[3:0] + 4'd9);
	endfunction

	function automatic upd_pkg::bundle_t put(input upd_pkg::bundle_t b, input logic [7:0] v);
		put = b;
		if (b.cnt != 2'd3) begin
			put.slot[b.cnt] = v;
			put.cnt = b.cnt + 2'd1;
		end
	endfunction

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign fresh_pct = (in_byte == upd_pkg::CH_PCT);
	assign fresh_val = (in_byte == upd_pkg::CH_PLUS) ? upd_pkg::CH_SPACE : in_byte;
	assign code = {hex_val(held_q), hex_val(in_byte)};

	always_comb begin
		bd = '0;
		phase_d = phase_q;
		held_d = held_q;
		if (in_byte != 8'h00) begin
			case (phase_q)
				upd_pkg::PH_PCT: begin
					if (is_hex(in_byte)) begin
						held_d = in_byte;
						phase_d = upd_pkg::PH_HEX;
					end else begin
						bd = put(bd, upd_pkg::CH_PCT);
						phase_d = upd_pkg::PH_IDLE;
						if (fresh_pct) phase_d = upd_pkg::PH_PCT;
						else bd = put(bd, fresh_val);
					end
				end
				upd_pkg::PH_HEX: begin
					phase_d = upd_pkg::PH_IDLE;
					held_d = 8'h00;
					if (is_hex(in_byte)) begin
						// drop a decoded carriage return
						if (code != upd_pkg::CH_CR) bd = put(bd, code);
					end else begin
						bd = put(bd, upd_pkg::CH_PCT);
						bd = put(bd, held_q);
						if (fresh_pct) phase_d = upd_pkg::PH_PCT;
						else bd = put(bd, fresh_val);
					end
				end
				default: begin
					phase_d = upd_pkg::PH_IDLE;
					if (fresh_pct) phase_d = upd_pkg::PH_PCT;
					else bd = put(bd, fresh_val);
				end
			endcase
		end
		if (in_last) begin
			// flush a pending escape literally
			if (phase_d == upd_pkg::PH_PCT) begin
				bd = put(bd, upd_pkg::CH_PCT);
			end else if (phase_d == upd_pkg::PH_HEX) begin
				bd = put(bd, upd_pkg::CH_PCT);
				bd = put(bd, held_d);
			end
			phase_d = upd_pkg::PH_IDLE;
			held_d = 8'h00;
			if (bd.cnt == 2'd0) begin
				bd.cnt = 2'd1;
				bd.bare = 1'b1;
			end
			bd.last = 1'b1;
		end
	end

	assign push      = accept && (bd.cnt != 2'd0);
	assign push_data = bd;
	assign stat.phase = phase_q;
	assign stat.busy  = (phase_q != upd_pkg::PH_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= upd_pkg::PH_IDLE;
			held_q <= 8'h00;
		end else if (accept) begin
			phase_q <= phase_d;
			held_q <= held_d;
		end
	end

endmodule

// ===== design/upd_queue.sv =====
// Short bundle queue between the front and back ends.
module upd_queue #(
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  upd_pkg::bundle_t push_data,
	input  logic             pop,
	output logic             full,
	output logic             empty,
	output upd_pkg::bundle_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

	upd_pkg::bundle_t mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			if (do_pop) rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			if (do_push && !do_pop) count_q <= count_q + CW'(1);
			else if (do_pop && !do_push) count_q <= count_q - CW'(1);
		end
	end

endmodule

// ===== design/upd_back.sv =====
// Back end: walks the head bundle one slot per cycle into the output register unless the output is stalled.
module upd_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  upd_pkg::bundle_t head,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       out_byte,
	output logic             out_has_byte,
	output logic             out_last
);

	logic [1:0] idx_q;
	logic       valid_q;
	logic       load;
	logic       at_end;

	assign load   = !valid_q || out_ready;
	assign at_end = (idx_q == head.cnt - 2'd1);
	assign pop    = load && !q_empty && at_end;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q <= 2'd0;
		end else if (load) begin
			valid_q <= !q_empty;
			if (!q_empty) idx_q <= at_end ? 2'd0 : idx_q + 2'd1;
		end
	end

	// payload: hold while the current transfer is stalled
	always_ff @(posedge clk) begin
		if (load && !q_empty) begin
			out_byte <= head.bare ? 8'h00 : head.slot[idx_q];
			out_has_byte <= !head.bare;
			out_last <= head.last && at_end;
		end
	end

endmodule

// ===== test/url_percent_decoder_tb.sv =====
// Self-checking testbench for the URL percent decoder: directed strings, random strings, stalls.
module url_percent_decoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_CYCLES = 1000;
	localparam int RANDOM_TARGET   = 130;
	localparam int HOLD_CYCLES     = 80;
	localparam int HOLD_AFTER      = 40;

	typedef struct packed {
		logic [7:0] b;
		logic       last;
	} enc_t;

	typedef struct packed {
		logic [7:0] b;
		logic       has;
		logic       last;
	} decoded_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] in_byte = 8'h00;
	logic       in_last = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_byte;
	logic       out_has_byte;
	logic       out_last;

	enc_t       raw_q[$];
	decoded_t   decoded_q[$];
	enc_t       next_enc;
	decoded_t   want;

	// decoder state mirror
	upd_pkg::phase_t esc_phase = upd_pkg::PH_IDLE;
	logic [7:0]      held = 8'h00;

	int errors = 0;
	int n_items = 0;
	int n_strings = 0;
	int n_in = 0;
	int n_out = 0;
	int burst_left = 0;
	int gap_left = 0;
	int hold_left = 0;
	bit hold_done = 0;
	int mode = 0;
	int mode_left = 0;

	url_percent_decoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_byte      (in_byte),
		.in_last      (in_last),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.out_has_byte (out_has_byte),
		.out_last     (out_last)
	);

	always #1 clk = ~clk;

	function automatic bit is_hex(input logic [7:0] b);
		return (b >= "0" && b <= "9") || (b >= "A" && b <= "F") || (b >= "a" && b <= "f");
	endfunction

	function automatic logic [3:0] nibble_of(input logic [7:0] b);
		logic [7:0] v;
		if (b <= "9")
			v = b - "0";
		else if (b <= "F")
			v = b - "A" + 8'd10;
		else
			v = b - "a" + 8'd10;
		return v[3:0];
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
		if (n < 4'd10)
			return 8'h30 + n;
		return (upper ? 8'h41 : 8'h61) + n - 8'd10;
	endfunction

	// Decode one accepted byte and queue the bytes it completes.
	function automatic void decode_step(input logic [7:0] b, input logic l);
		decoded_t res[$];
		logic [7:0] code;
		bit redo;
		redo = 0;
		if (b != 8'h00) begin
			case (esc_phase)
				upd_pkg::PH_PCT: begin
					if (is_hex(b)) begin
						held = b;
						esc_phase = upd_pkg::PH_HEX;
					end else begin
						esc_phase = upd_pkg::PH_IDLE;
						res.push_back(decoded_t'{upd_pkg::CH_PCT, 1'b1, 1'b0});
						redo = 1;
					end
				end
				upd_pkg::PH_HEX: begin
					if (is_hex(b)) begin
						code = {nibble_of(held), nibble_of(b)};
						if (code != upd_pkg::CH_CR)
							res.push_back(decoded_t'{code, 1'b1, 1'b0});
					end else begin
						res.push_back(decoded_t'{upd_pkg::CH_PCT, 1'b1, 1'b0});
						res.push_back(decoded_t'{held, 1'b1, 1'b0});
						redo = 1;
					end
					esc_phase = upd_pkg::PH_IDLE;
					held = 8'h00;
				end
				default: redo = 1;
			endcase
			if (redo) begin
				if (b == upd_pkg::CH_PCT)
					esc_phase = upd_pkg::PH_PCT;
				else if (b == upd_pkg::CH_PLUS)
					res.push_back(decoded_t'{upd_pkg::CH_SPACE, 1'b1, 1'b0});
				else
					res.push_back(decoded_t'{b, 1'b1, 1'b0});
			end
		end
		if (l) begin
			if (esc_phase == upd_pkg::PH_PCT) begin
				res.push_back(decoded_t'{upd_pkg::CH_PCT, 1'b1, 1'b0});
			end else if (esc_phase == upd_pkg::PH_HEX) begin
				res.push_back(decoded_t'{upd_pkg::CH_PCT, 1'b1, 1'b0});
				res.push_back(decoded_t'{held, 1'b1, 1'b0});
			end
			esc_phase = upd_pkg::PH_IDLE;
			held = 8'h00;
			if (res.size() == 0)
				res.push_back(decoded_t'{8'h00, 1'b0, 1'b0});
			res[res.size() - 1].last = 1'b1;
		end
		foreach (res[i])
			decoded_q.push_back(res[i]);
	endfunction

	task automatic push_item(input logic [7:0] b, input logic l);
		raw_q.push_back(enc_t'{b, l});
		if (b != 8'h00 || l)
			n_items++;
		if (l)
			n_strings++;
	endtask

	// Sender: bursts of transfers separated by random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_byte <= 8'h00;
			in_last <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (raw_q.size() > 0) begin
				next_enc = raw_q.pop_front();
				in_valid <= 1'b1;
				in_byte <= next_enc.b;
				in_last <= next_enc.last;
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 16);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: changing stall pattern, plus one long hold-off to back up the input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (!hold_done && n_in >= HOLD_AFTER) begin
			hold_done = 1;
			hold_left = HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				mode = $urandom_range(0, 2);
				mode_left = $urandom_range(8, 40);
			end
			mode_left--;
			case (mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 3) != 0);
				default: out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// Check results first, then predict from the byte taken at this edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			n_out++;
			if (decoded_q.size() == 0) begin
				$error("unexpected result: out_byte %02h has %0b last %0b",
					out_byte, out_has_byte, out_last);
				errors++;
			end else begin
				want = decoded_q.pop_front();
				if (out_byte !== want.b) begin
					$error("out_byte: expected %02h, got %02h", want.b, out_byte);
					errors++;
				end
				if (out_has_byte !== want.has) begin
					$error("out_has_byte: expected %0b, got %0b", want.has, out_has_byte);
					errors++;
				end
				if (out_last !== want.last) begin
					$error("out_last: expected %0b, got %0b", want.last, out_last);
					errors++;
				end
			end
		end
		if (arst_n && in_valid && in_ready) begin
			n_in++;
			decode_step(in_byte, in_last);
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		@(posedge arst_n);
		while (idle < WATCHDOG_CYCLES) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle = 0;
			else
				idle++;
		end
		$display("FAIL url_percent_decoder");
		$finish;
	end

	initial begin : stimulus
		enc_t s[$];
		int len;
		int r;
		logic [7:0] v;
		logic [7:0] c;

		// directed: escapes, plus, dropped CR, escaped zero, broken escapes, flushes
		push_item(upd_pkg::CH_PCT, 1'b0); push_item("4", 1'b0); push_item("1", 1'b0);
		push_item(upd_pkg::CH_PLUS, 1'b0);
		push_item(upd_pkg::CH_PCT, 1'b0); push_item("0", 1'b0); push_item("D", 1'b0);
		push_item(upd_pkg::CH_PCT, 1'b0); push_item("0", 1'b0); push_item("0", 1'b1);
		push_item(upd_pkg::CH_PCT, 1'b0); push_item("z", 1'b0);
		push_item(upd_pkg::CH_PCT, 1'b0); push_item("a", 1'b0); push_item("g", 1'b1);
		push_item(upd_pkg::CH_PCT, 1'b0); push_item(upd_pkg::CH_PCT, 1'b0);
		push_item("f", 1'b0);
		push_item("F", 1'b0);
		push_item(8'hFF, 1'b0); push_item(8'h01, 1'b0);
		push_item(8'h00, 1'b0);
		push_item(upd_pkg::CH_PCT, 1'b1);
		push_item(upd_pkg::CH_PCT, 1'b0); push_item("9", 1'b1);
		push_item(8'h00, 1'b1);

		// random strings, mostly well-formed escapes with random content
		while (n_items < RANDOM_TARGET) begin
			s.delete();
			len = $urandom_range(1, 8);
			repeat (len) begin
				r = $urandom_range(0, 99);
				if (r < 40) begin
					v = ($urandom_range(0, 9) == 0) ? upd_pkg::CH_CR :
						8'($urandom_range(0, 255));
					s.push_back(enc_t'{upd_pkg::CH_PCT, 1'b0});
					s.push_back(enc_t'{hex_char(v[7:4], 1'($urandom_range(0, 1))), 1'b0});
					s.push_back(enc_t'{hex_char(v[3:0], 1'($urandom_range(0, 1))), 1'b0});
				end else if (r < 55) begin
					s.push_back(enc_t'{upd_pkg::CH_PLUS, 1'b0});
				end else if (r < 85) begin
					s.push_back(enc_t'{8'($urandom_range(1, 255)), 1'b0});
				end else if (r < 95) begin
					// escape cut short; whatever follows breaks or completes it
					s.push_back(enc_t'{upd_pkg::CH_PCT, 1'b0});
					if ($urandom_range(0, 1)) begin
						c = hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
						s.push_back(enc_t'{c, 1'b0});
					end
				end else begin
					s.push_back(enc_t'{8'h00, 1'b0});
				end
			end
			if ($urandom_range(0, 7) == 0)
				s.push_back(enc_t'{8'h00, 1'b1});
			else
				s[s.size() - 1].last = 1'b1;
			foreach (s[i])
				push_item(s[i].b, s[i].last);
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (raw_q.size() != 0 || in_valid)
			@(posedge clk);
		while (decoded_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Covered %0d strings, %0d encoded bytes in, %0d decoded results checked.",
			n_strings, n_in, n_out);
		if (errors == 0)
			$display("PASS url_percent_decoder");
		else
			$display("FAIL url_percent_decoder");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/upd_pkg.sv
design/upd_front.sv
design/upd_queue.sv
design/upd_back.sv
design/url_percent_decoder.sv
test/url_percent_decoder_tb.sv
